// ===== src/lock_manager_with_wait_queue_macros.svh =====
// Assertion helpers for the lock manager checker.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef LOCK_MANAGER_WITH_WAIT_QUEUE_MACROS_SVH
`define LOCK_MANAGER_WITH_WAIT_QUEUE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define LMWQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock manager check failed");

// Consequent holds in the cycle after the antecedent.
`define LMWQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock manager check failed");

`endif

// ===== src/lmwq_pkg.sv =====
`timescale 1ns / 1ps

package lmwq_pkg;

    // Action codes
    localparam logic [1:0] ACT_CREATE  = 2'd0;
    localparam logic [1:0] ACT_ACQUIRE = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_QUEUED = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_ERROR  = 2'd3;

    // Lock IDs start here
    localparam logic [15:0] LOCK_ID_BASE = 16'h7000;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Strobes broadcast to every wait-list cell
    typedef struct packed {
        logic load_match;
        logic push;
        logic pop;
    } lmwq_ctl_t;

endpackage

// ===== src/lmwq_if.sv =====
`timescale 1ns / 1ps

interface lmwq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] lock_ident;
    logic [7:0]  task_ident;
    logic        from_isr;

    modport source (output valid, action, lock_ident, task_ident, from_isr, input ready);
    modport sink   (input valid, action, lock_ident, task_ident, from_isr, output ready);
endinterface

interface lmwq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] created_ident;
    logic        woken_valid;
    logic [7:0]  woken_task;

    modport source (output valid, status, created_ident, woken_valid, woken_task, input ready);
    modport sink   (input valid, status, created_ident, woken_valid, woken_task, output ready);
endinterface

// ===== src/lmwq_cell.sv =====
`timescale 1ns / 1ps

module lmwq_cell
    import lmwq_pkg::*;
#(
    parameter int SLOT_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lmwq_ctl_t         ctl,
    input  logic [SLOT_W-1:0] match_slot,
    input  logic [SLOT_W-1:0] push_slot,
    input  logic [7:0]        push_task,
    input  logic              prev_valid,
    input  logic              found_in,
    input  logic [7:0]        wake_in,
    input  logic              next_valid,
    input  logic [SLOT_W-1:0] next_slot,
    input  logic [7:0]        next_task,
    output logic              valid,
    output logic [SLOT_W-1:0] slot,
    output logic [7:0]        task_id,
    output logic              found_out,
    output logic [7:0]        wake_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [7:0]        task_reg;
    logic [7:0]        task_next;
    logic              match_reg;
    logic              hit;
    logic              first;

    // Flag the oldest waiter on the released slot
    assign hit       = valid_reg & match_reg;
    assign first     = hit & ~found_in;
    assign found_out = found_in | hit;
    assign wake_out  = wake_in | (first ? task_reg : 8'd0);

    assign valid   = valid_reg;
    assign slot    = slot_reg;
    assign task_id = task_reg;

    // Shift down from the match onward on pop, fill the first empty cell on push
    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        task_next  = task_reg;
        if (ctl.pop && found_out)
        begin
            valid_next = next_valid;
            slot_next  = next_slot;
            task_next  = next_task;
        end
        else if (ctl.push && prev_valid && !valid_reg)
        begin
            valid_next = 1'b1;
            slot_next  = push_slot;
            task_next  = push_task;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload and the match flag of the current beat
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        task_reg <= task_next;
        if (ctl.load_match)
        begin
            match_reg <= (slot_reg == match_slot);
        end
    end

endmodule

// ===== src/lmwq_queue.sv =====
`timescale 1ns / 1ps

module lmwq_queue
    import lmwq_pkg::*;
#(
    parameter int SLOT_W = 4,
    parameter int DEPTH  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lmwq_ctl_t         ctl,
    input  logic [SLOT_W-1:0] match_slot,
    input  logic [SLOT_W-1:0] push_slot,
    input  logic [7:0]        push_task,
    output logic              full,
    output logic              found,
    output logic [7:0]        wake_task
);

    // Index DEPTH is an empty sentinel behind the last cell
    logic [DEPTH:0]    cv;
    logic [SLOT_W-1:0] cs [DEPTH+1];
    logic [7:0]        ct [DEPTH+1];
    logic [DEPTH:0]    fc;
    logic [7:0]        wk [DEPTH+1];

    assign cv[DEPTH] = 1'b0;
    assign cs[DEPTH] = '0;
    assign ct[DEPTH] = 8'd0;
    assign fc[0]     = 1'b0;
    assign wk[0]     = 8'd0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic prev_v;
            if (i == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = cv[i-1];
            end

            lmwq_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .match_slot (match_slot),
                .push_slot  (push_slot),
                .push_task  (push_task),
                .prev_valid (prev_v),
                .found_in   (fc[i]),
                .wake_in    (wk[i]),
                .next_valid (cv[i+1]),
                .next_slot  (cs[i+1]),
                .next_task  (ct[i+1]),
                .valid      (cv[i]),
                .slot       (cs[i]),
                .task_id    (ct[i]),
                .found_out  (fc[i+1]),
                .wake_out   (wk[i+1])
            );
        end
    endgenerate

    assign full      = cv[DEPTH-1];
    assign found     = fc[DEPTH];
    assign wake_task = wk[DEPTH];

endmodule

// ===== src/lock_manager_with_wait_queue.sv =====
`timescale 1ns / 1ps

// Lock manager with a shared, ordered wait list.
// req carries one request per beat: action (create, acquire, release), lock_ident,
// task_ident and from_isr. rsp returns exactly one result beat per request:
// status, created_ident, woken_valid and woken_task.
// Each request is accepted in ST_IDLE, which reads the owner memory and loads
// the per-cell slot match in the wait list; ST_EXEC then resolves the oldest
// match along the cell chain, compacts the list and updates the lock table.
// A new request is taken only after the previous one is in the rsp register.
// When rsp is stalled, the finished result holds in the rsp register; one more
// request is accepted and then waits in ST_EXEC until the register frees.
// Reset clears the lock table, the created count, the hold flags and the wait
// list valid bits; the block is ready in the first cycle after reset.
// Lock IDs are 0x7000 plus the slot; slots are handed out in increasing order.
module lock_manager_with_wait_queue
    import lmwq_pkg::*;
#(
    parameter int NUM_LOCKS   = 16,
    parameter int MAX_WAITERS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    lmwq_in_if.sink       req,
    lmwq_out_if.source    rsp
);

    localparam int SLOT_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_LOCKS + 1);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  created_reg;
    logic [CNT_W-1:0]  created_next;
    logic [NUM_LOCKS-1:0] held_reg;
    logic [NUM_LOCKS-1:0] held_next;
    logic [7:0]        owner_mem [NUM_LOCKS];
    logic [7:0]        owner_rd_reg;

    logic [1:0]        act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              id_ok_reg;
    logic [7:0]        task_reg;
    logic              isr_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        status_reg;
    logic [15:0]       created_id_reg;
    logic              woken_valid_reg;
    logic [7:0]        woken_task_reg;

    logic              accept;
    logic              commit;
    logic [15:0]       slot16;
    logic [SLOT_W-1:0] slot_in;
    logic              id_ok_in;
    logic              held_cur;
    logic [1:0]        res_status;
    logic [15:0]       res_created;
    logic              do_create;
    logic              do_grant;
    logic              do_free;
    logic              do_push;
    logic              do_pop;
    lmwq_ctl_t         q_ctl;
    logic              q_full;
    logic              q_found;
    logic [7:0]        q_wake;

    // Decode the incoming ID
    assign slot16   = req.lock_ident - LOCK_ID_BASE;
    assign slot_in  = slot16[SLOT_W-1:0];
    assign id_ok_in = (slot16 < 16'(created_reg));

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);
    assign held_cur  = held_reg[slot_reg];

    // Sequence: accept, then commit when the rsp register frees
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Resolve the request
    always_comb
    begin
        res_status  = STAT_ERROR;
        res_created = 16'd0;
        do_create   = 1'b0;
        do_grant    = 1'b0;
        do_free     = 1'b0;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        unique case (act_reg)
            ACT_CREATE:
            begin
                if (created_reg < CNT_W'(NUM_LOCKS))
                begin
                    res_status  = STAT_OK;
                    res_created = LOCK_ID_BASE + 16'(created_reg);
                    do_create   = 1'b1;
                end
            end
            ACT_ACQUIRE:
            begin
                if (id_ok_reg)
                begin
                    priority if (!held_cur)
                    begin
                        res_status = STAT_OK;
                        do_grant   = 1'b1;
                    end
                    else if (isr_reg)
                    begin
                        res_status = STAT_ERROR;
                    end
                    else if (q_full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        res_status = STAT_QUEUED;
                        do_push    = 1'b1;
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (id_ok_reg && held_cur && (owner_rd_reg == task_reg))
                begin
                    res_status = STAT_OK;
                    do_free    = 1'b1;
                    do_pop     = q_found;
                end
            end
            default:
            begin
                res_status = STAT_ERROR;
            end
        endcase
    end

    // Update the lock table on commit
    always_comb
    begin
        created_next = created_reg;
        held_next    = held_reg;
        if (commit && do_create)
        begin
            created_next = created_reg + CNT_W'(1);
        end
        if (commit && do_grant)
        begin
            held_next[slot_reg] = 1'b1;
        end
        if (commit && do_free)
        begin
            held_next[slot_reg] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            created_reg   <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            created_reg   <= created_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= req.action;
            slot_reg  <= slot_in;
            id_ok_reg <= id_ok_in;
            task_reg  <= req.task_ident;
            isr_reg   <= req.from_isr;
        end
    end

    // Owner memory: read on accept, write on grant
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            owner_rd_reg <= owner_mem[slot_in];
        end
        if (commit && do_grant)
        begin
            owner_mem[slot_reg] <= task_reg;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg      <= res_status;
            created_id_reg  <= res_created;
            woken_valid_reg <= do_pop;
            woken_task_reg  <= do_pop ? q_wake : 8'd0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.created_ident = created_id_reg;
    assign rsp.woken_valid   = woken_valid_reg;
    assign rsp.woken_task    = woken_task_reg;

    // Wait list
    assign q_ctl.load_match = accept;
    assign q_ctl.push       = commit & do_push;
    assign q_ctl.pop        = commit & do_pop;

    lmwq_queue #(
        .SLOT_W (SLOT_W),
        .DEPTH  (MAX_WAITERS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (q_ctl),
        .match_slot (slot_in),
        .push_slot  (slot_reg),
        .push_task  (task_reg),
        .full       (q_full),
        .found      (q_found),
        .wake_task  (q_wake)
    );

endmodule

// ===== src/lmwq_checker.sv =====
`timescale 1ns / 1ps
`include "lock_manager_with_wait_queue_macros.svh"

module lmwq_checker
    import lmwq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [15:0] rsp_created,
    input logic        rsp_woken_valid,
    input logic [7:0]  rsp_woken_task
);

    // One request in flight: ready drops right after an accept
    `LMWQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // A stalled result beat holds
    `LMWQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

    // A created ID comes only with a successful create
    `LMWQ_ASSERT_NOW(a_created_ok, rsp_valid && (rsp_created != 16'd0), rsp_status == STAT_OK)

    // A wakeup comes only with a successful release
    `LMWQ_ASSERT_NOW(a_woken_ok, rsp_valid && rsp_woken_valid, rsp_status == STAT_OK)

    // No woken task without a wakeup
    `LMWQ_ASSERT_NOW(a_woken_zero, rsp_valid && !rsp_woken_valid, rsp_woken_task == 8'd0)

endmodule

bind lock_manager_with_wait_queue lmwq_checker u_lmwq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_created     (rsp.created_ident),
    .rsp_woken_valid (rsp.woken_valid),
    .rsp_woken_task  (rsp.woken_task)
);

// ===== test/lock_table_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the lock manager, keeps its own copy of the lock
// table and the wait list, and compares every reply beat against the oldest
// prediction.
module lock_table_checker
    import lmwq_pkg::*;
#(
    parameter int NUM_LOCKS   = 16,
    parameter int MAX_WAITERS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    lmwq_in_if   req,
    lmwq_out_if  rsp,
    output int   fails,
    output int   pending,
    output int   checked,
    output int   wakeups,
    output int   full_replies
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] created_ident;
        logic        woken_valid;
        logic [7:0]  woken_task;
    } lock_reply_t;

    // Lock table
    logic        created_q [NUM_LOCKS];
    logic        held_q    [NUM_LOCKS];
    logic [7:0]  owner_q   [NUM_LOCKS];
    logic        owned_q   [NUM_LOCKS];

    // Wait list, oldest entry at index 0
    int          wait_slot [MAX_WAITERS];
    logic [7:0]  wait_task [MAX_WAITERS];
    int          wait_len;

    lock_reply_t replies_due [$];

    // Apply one request to the table copy and return the reply it earns
    function automatic lock_reply_t serve_request(logic [1:0] act, logic [15:0] ident,
                                                  logic [7:0] who, logic isr);
        lock_reply_t r;
        logic [15:0] offs;
        int          slot;
        bit          known;
        int          hit;
        r = '{status: STAT_ERROR, created_ident: 16'd0, woken_valid: 1'b0,
              woken_task: 8'd0};
        offs = ident - LOCK_ID_BASE;
        slot = offs;
        known = 1'b0;
        if (slot < NUM_LOCKS)
        begin
            known = created_q[slot];
        end
        case (act)
            ACT_CREATE:
            begin
                for (int i = 0; i < NUM_LOCKS; i++)
                begin
                    if (!created_q[i])
                    begin
                        created_q[i] = 1'b1;
                        held_q[i] = 1'b0;
                        owned_q[i] = 1'b0;
                        r.created_ident = LOCK_ID_BASE + 16'(i);
                        r.status = STAT_OK;
                        break;
                    end
                end
            end
            ACT_ACQUIRE:
            begin
                if (known)
                begin
                    if (!held_q[slot])
                    begin
                        held_q[slot] = 1'b1;
                        owner_q[slot] = who;
                        owned_q[slot] = 1'b1;
                        r.status = STAT_OK;
                    end
                    else if (isr)
                    begin
                        r.status = STAT_ERROR;
                    end
                    else if (wait_len >= MAX_WAITERS)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        wait_slot[wait_len] = slot;
                        wait_task[wait_len] = who;
                        wait_len++;
                        r.status = STAT_QUEUED;
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (known && owned_q[slot] && owner_q[slot] == who)
                begin
                    held_q[slot] = 1'b0;
                    owned_q[slot] = 1'b0;
                    r.status = STAT_OK;
                    // find the oldest waiter on this lock, then close the gap
                    hit = -1;
                    for (int i = 0; i < wait_len; i++)
                    begin
                        if (hit < 0 && wait_slot[i] == slot)
                        begin
                            hit = i;
                        end
                    end
                    if (hit >= 0)
                    begin
                        r.woken_valid = 1'b1;
                        r.woken_task = wait_task[hit];
                        for (int i = hit; i + 1 < wait_len; i++)
                        begin
                            wait_slot[i] = wait_slot[i + 1];
                            wait_task[i] = wait_task[i + 1];
                        end
                        wait_len--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    initial
    begin
        fails = 0;
        pending = 0;
        checked = 0;
        wakeups = 0;
        full_replies = 0;
    end

    // Compare reply beats first, then queue the prediction for a new request
    always @(posedge clk)
    begin
        lock_reply_t got;
        lock_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                created_q[i] = 1'b0;
                held_q[i] = 1'b0;
                owner_q[i] = 8'd0;
                owned_q[i] = 1'b0;
            end
            wait_len = 0;
            replies_due.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{status: rsp.status, created_ident: rsp.created_ident,
                        woken_valid: rsp.woken_valid, woken_task: rsp.woken_task};
                checked++;
                if (got.woken_valid)
                begin
                    wakeups++;
                end
                if (got.status == STAT_FULL)
                begin
                    full_replies++;
                end
                if (replies_due.size() == 0)
                begin
                    $error("reply beat with no request outstanding: status %0d", got.status);
                    fails++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.created_ident !== want.created_ident)
                    begin
                        $error("created_ident: expected 0x%04h, got 0x%04h",
                               want.created_ident, got.created_ident);
                        fails++;
                    end
                    if (got.woken_valid !== want.woken_valid)
                    begin
                        $error("woken_valid: expected %0b, got %0b",
                               want.woken_valid, got.woken_valid);
                        fails++;
                    end
                    if (got.woken_task !== want.woken_task)
                    begin
                        $error("woken_task: expected %0d, got %0d",
                               want.woken_task, got.woken_task);
                        fails++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                replies_due.push_back(serve_request(req.action, req.lock_ident,
                                                    req.task_ident, req.from_isr));
            end
        end
        pending = replies_due.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lmwq_pkg::*;

    localparam int         LOCKS        = 16;
    localparam int         WAITERS      = 16;
    localparam int         RANDOM_ITEMS = 528;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    logic clk;
    logic rst_n;

    lmwq_in_if  req_ch ();
    lmwq_out_if rsp_ch ();

    int fails;
    int pending;
    int checked;
    int wakeups;
    int full_replies;

    int tx_idle_pct;
    int rx_idle_pct;
    int acquire_share;
    int sent;

    // Rough view of the lock table used only to steer the stimulus
    int         made;
    logic       held_sh  [LOCKS];
    logic [7:0] owner_sh [LOCKS];

    lock_manager_with_wait_queue #(
        .NUM_LOCKS   (LOCKS),
        .MAX_WAITERS (WAITERS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lock_table_checker #(
        .NUM_LOCKS   (LOCKS),
        .MAX_WAITERS (WAITERS)
    ) lock_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fails        (fails),
        .pending      (pending),
        .checked      (checked),
        .wakeups      (wakeups),
        .full_replies (full_replies)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the reply channel at random
    always @(negedge clk)
    begin
        rsp_ch.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Drive one request beat, wait for it to be taken, track its effect
    task automatic send_request(logic [1:0] act, logic [15:0] ident, logic [7:0] who,
                                logic isr);
        logic [15:0] offs;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.lock_ident <= ident;
        req_ch.task_ident <= who;
        req_ch.from_isr   <= isr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
        offs = ident - LOCK_ID_BASE;
        case (act)
            ACT_CREATE:
            begin
                if (made < LOCKS)
                begin
                    held_sh[made] = 1'b0;
                    made++;
                end
            end
            ACT_ACQUIRE:
            begin
                if (offs < made && !held_sh[offs])
                begin
                    held_sh[offs] = 1'b1;
                    owner_sh[offs] = who;
                end
            end
            ACT_RELEASE:
            begin
                if (offs < made && held_sh[offs] && owner_sh[offs] == who)
                begin
                    held_sh[offs] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    // Mostly well-formed traffic on created locks, with some noise mixed in
    task automatic random_request();
        int          pick;
        int          slot;
        logic [7:0]  who;
        logic [15:0] ident;
        pick = $urandom_range(0, 99);
        if (pick < 5 || made == 0)
        begin
            send_request(ACT_CREATE, 16'($urandom), 8'($urandom), 1'($urandom));
        end
        else if (pick < 13)
        begin
            // stray IDs: fully random or in and just past the valid range
            ident = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                : LOCK_ID_BASE + 16'($urandom_range(0, 31));
            send_request(2'($urandom_range(0, 3)), ident, 8'($urandom), 1'($urandom));
        end
        else
        begin
            slot = $urandom_range(0, made - 1);
            ident = LOCK_ID_BASE + 16'(slot);
            if ($urandom_range(0, 99) < acquire_share)
            begin
                send_request(ACT_ACQUIRE, ident, 8'($urandom),
                             $urandom_range(0, 9) == 0);
            end
            else
            begin
                who = (held_sh[slot] && $urandom_range(0, 99) < 88) ? owner_sh[slot]
                                                                    : 8'($urandom);
                send_request(ACT_RELEASE, ident, who, 1'($urandom));
            end
        end
    endtask

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_CREATE;
        req_ch.lock_ident = 16'd0;
        req_ch.task_ident = 8'd0;
        req_ch.from_isr   = 1'b0;
        rsp_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        made              = 0;
        sent              = 0;
        acquire_share     = 60;
        tx_idle_pct       = 16;
        rx_idle_pct       = 45;
        for (int i = 0; i < LOCKS; i++)
        begin
            held_sh[i] = 1'b0;
            owner_sh[i] = 8'd0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unused action and bad IDs before any lock exists, then two creates
        send_request(ACT_UNUSED,  16'h7000, 8'd1,   1'b0);
        send_request(ACT_ACQUIRE, 16'h7000, 8'd1,   1'b0);
        send_request(ACT_RELEASE, 16'h7000, 8'd1,   1'b0);
        send_request(ACT_CREATE,  16'hFFFF, 8'hFF,  1'b1);
        send_request(ACT_CREATE,  16'h0000, 8'h00,  1'b0);
        // grant, same-task queueing, interrupt caller on held and free locks
        send_request(ACT_ACQUIRE, 16'h7000, 8'd0,   1'b0);
        send_request(ACT_ACQUIRE, 16'h7000, 8'd0,   1'b0);
        send_request(ACT_ACQUIRE, 16'h7000, 8'd255, 1'b1);
        send_request(ACT_ACQUIRE, 16'h7001, 8'd255, 1'b1);
        send_request(ACT_ACQUIRE, 16'h7001, 8'd7,   1'b0);
        send_request(ACT_ACQUIRE, 16'h7000, 8'd9,   1'b0);
        // release by a stranger, by the owner, and with no owner left
        send_request(ACT_RELEASE, 16'h7000, 8'd5,   1'b0);
        send_request(ACT_RELEASE, 16'h7000, 8'd0,   1'b0);
        send_request(ACT_RELEASE, 16'h7000, 8'd0,   1'b0);
        send_request(ACT_RELEASE, 16'h7001, 8'd255, 1'b1);
        // out-of-range and never-created IDs
        send_request(ACT_ACQUIRE, 16'h7010, 8'd3,   1'b0);
        send_request(ACT_ACQUIRE, 16'hFFFF, 8'd3,   1'b0);
        send_request(ACT_ACQUIRE, 16'h0000, 8'd3,   1'b0);
        send_request(ACT_ACQUIRE, 16'h6FFF, 8'd3,   1'b0);
        send_request(ACT_ACQUIRE, 16'h700F, 8'd3,   1'b0);
        send_request(ACT_RELEASE, 16'hFFFF, 8'd3,   1'b0);
        // wake the last waiter, then a release with nobody waiting
        send_request(ACT_ACQUIRE, 16'h7000, 8'd3,   1'b0);
        send_request(ACT_RELEASE, 16'h7000, 8'd3,   1'b0);
        send_request(ACT_ACQUIRE, 16'h7001, 8'd4,   1'b0);
        send_request(ACT_RELEASE, 16'h7001, 8'd4,   1'b0);

        // Random traffic over three idle mixes, swinging between fill and drain
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 45 : 0;
            rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 16 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if (n % 40 == 0)
                begin
                    acquire_share = ($urandom_range(0, 1) == 0) ? 75 : 35;
                end
                random_request();
            end
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding replies
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Sent %0d requests under three idle mixes; %0d reply beats checked.",
                 sent, checked);
        $display("Woken waiters: %0d, wait-list-full replies: %0d, locks created: %0d.",
                 wakeups, full_replies, made);
        if (fails == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/lmwq_pkg.sv
src/lmwq_if.sv
src/lmwq_cell.sv
src/lmwq_queue.sv
src/lock_manager_with_wait_queue.sv
src/lmwq_checker.sv
test/lock_table_checker.sv
test/tb.sv
